// ===== hw/rtl/dcf_pkg.sv =====
// dcf_pkg: types, constants and register indexes for the DCF77 pulse decoder.
// Used by dcf_core, dcf_outbuf and dcf77_pulse_time_decoder; depends on nothing.
`default_nettype none

package dcf_pkg;

    localparam int TICK_W     = 16;
    localparam int COUNT_W    = 6;
    localparam int CAPTURE_W  = 32;
    localparam int MINUTE_W   = 7;
    localparam int HOUR_W     = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [TICK_W-1:0] GAP_RESET       = 16'd14000;
    localparam logic [TICK_W-1:0] ZERO_LOW_RESET  = 16'd7020;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 16'd20280;
    localparam logic [TICK_W-1:0] ONE_LOW_RESET   = 16'd21840;
    localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 16'd35880;

    localparam logic [COUNT_W-1:0] CAPTURE_FIRST = 6'd15;
    localparam logic [COUNT_W-1:0] CAPTURE_END   = 6'd47;
    localparam logic [COUNT_W-1:0] CAPTURE_TOP   = 6'd46;
    localparam logic [COUNT_W-1:0] DECODE_COUNT  = 6'd50;
    localparam logic [COUNT_W-1:0] WRAP_COUNT    = 6'd58;

    localparam logic [MINUTE_W-1:0] LAST_MINUTE = 7'd59;
    localparam logic [HOUR_W-1:0]   LAST_HOUR   = 6'd23;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAP       = 3'd0,
        CFG_ZERO_LOW  = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ONE_LOW   = 3'd3,
        CFG_ONE_HIGH  = 3'd4
    } cfg_addr_t;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_ONE  = 2'd2,
        CLS_GAP  = 2'd3
    } pulse_class_t;

    typedef struct packed {
        logic [TICK_W-1:0] gap_threshold;
        logic [TICK_W-1:0] zero_window_low;
        logic [TICK_W-1:0] zero_window_high;
        logic [TICK_W-1:0] one_window_low;
        logic [TICK_W-1:0] one_window_high;
    } dcf_cfg_t;

    // field order matches the result tdata, last member in the lowest bits
    typedef struct packed {
        logic [MINUTE_W-1:0] minute_value;
        logic [HOUR_W-1:0]   hour_value;
        logic                frame_error;
        logic                time_accepted;
        pulse_class_t        pulse_class;
    } dcf_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dcf_core.sv =====
// dcf_core: decoder state and the single-pass update for one edge item.
// Depends on dcf_pkg.
`default_nettype none

module dcf_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_push,
    input  wire logic                          new_level,
    input  wire logic [dcf_pkg::TICK_W-1:0]    phase_ticks,
    input  wire dcf_pkg::dcf_cfg_t             cfg,
    output dcf_pkg::dcf_res_t                  res
);

    logic                            synced_reg, synced_next;
    logic [dcf_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [dcf_pkg::CAPTURE_W-1:0]   capture_reg, capture_next;
    logic [dcf_pkg::MINUTE_W-1:0]    minute_now_reg, minute_now_next;
    logic [dcf_pkg::HOUR_W-1:0]      hour_now_reg, hour_now_next;
    logic [dcf_pkg::MINUTE_W-1:0]    minute_before_reg, minute_before_next;
    logic [dcf_pkg::HOUR_W-1:0]      hour_before_reg, hour_before_next;

    logic                            is_gap, in_zero, in_one, in_capture, consecutive;
    logic [dcf_pkg::COUNT_W-1:0]     count_inc, cap_pos;
    logic [dcf_pkg::MINUTE_W:0]      minute_inc;
    logic [dcf_pkg::HOUR_W:0]        hour_inc;
    logic [dcf_pkg::MINUTE_W-1:0]    dec_minute;
    logic [dcf_pkg::HOUR_W-1:0]      dec_hour;

    assign is_gap    = phase_ticks > cfg.gap_threshold;
    assign in_zero   = (cfg.zero_window_low < phase_ticks) && (phase_ticks < cfg.zero_window_high);
    assign in_one    = (cfg.one_window_low < phase_ticks) && (phase_ticks < cfg.one_window_high);
    assign count_inc = count_reg + 1'b1;
    assign in_capture = (count_reg >= dcf_pkg::CAPTURE_FIRST) && (count_reg < dcf_pkg::CAPTURE_END);
    // bit 15 lands in word bit 31, bit 46 in word bit 0
    assign cap_pos   = dcf_pkg::CAPTURE_TOP - count_reg;

    assign minute_inc = {1'b0, minute_before_reg} + 1'b1;
    assign hour_inc   = {1'b0, hour_before_reg} + 1'b1;

    always_comb begin
        consecutive = 1'b0;
        if (minute_inc == {1'b0, minute_now_reg} && hour_before_reg == hour_now_reg) begin
            consecutive = 1'b1;
        end
        if (minute_before_reg == dcf_pkg::LAST_MINUTE && minute_now_reg == '0) begin
            if (hour_inc == {1'b0, hour_now_reg}) begin
                consecutive = 1'b1;
            end
            if (hour_before_reg == dcf_pkg::LAST_HOUR && hour_now_reg == '0) begin
                consecutive = 1'b1;
            end
        end
    end

    // BCD weights; minute from word bits 25..19, hour from 17..12
    always_comb begin
        dec_minute = 7'(capture_next[25])
                   + (capture_next[24] ? 7'd2  : 7'd0)
                   + (capture_next[23] ? 7'd4  : 7'd0)
                   + (capture_next[22] ? 7'd8  : 7'd0)
                   + (capture_next[21] ? 7'd10 : 7'd0)
                   + (capture_next[20] ? 7'd20 : 7'd0)
                   + (capture_next[19] ? 7'd40 : 7'd0);
        dec_hour   = 6'(capture_next[17])
                   + (capture_next[16] ? 6'd2  : 6'd0)
                   + (capture_next[15] ? 6'd4  : 6'd0)
                   + (capture_next[14] ? 6'd8  : 6'd0)
                   + (capture_next[13] ? 6'd10 : 6'd0)
                   + (capture_next[12] ? 6'd20 : 6'd0);
    end

    always_comb begin
        synced_next        = synced_reg;
        count_next         = count_reg;
        capture_next       = capture_reg;
        minute_now_next    = minute_now_reg;
        hour_now_next      = hour_now_reg;
        minute_before_next = minute_before_reg;
        hour_before_next   = hour_before_reg;
        res.pulse_class    = dcf_pkg::CLS_NONE;
        res.time_accepted  = 1'b0;
        res.frame_error    = 1'b0;

        if (new_level) begin
            if (is_gap) begin
                synced_next        = 1'b1;
                count_next         = '0;
                capture_next       = '0;
                res.pulse_class    = dcf_pkg::CLS_GAP;
                res.time_accepted  = consecutive;
                res.frame_error    = !consecutive;
                minute_before_next = minute_now_reg;
                hour_before_next   = hour_now_reg;
            end
        end else begin
            if (synced_reg) begin
                if (in_zero) begin
                    count_next      = count_inc;
                    res.pulse_class = dcf_pkg::CLS_ZERO;
                end else if (in_one) begin
                    if (in_capture) begin
                        capture_next[cap_pos[4:0]] = 1'b1;
                    end
                    count_next      = count_inc;
                    res.pulse_class = dcf_pkg::CLS_ONE;
                end
                if (count_next == dcf_pkg::DECODE_COUNT) begin
                    minute_now_next = dec_minute;
                    hour_now_next   = dec_hour;
                end
            end
            if (count_next == dcf_pkg::WRAP_COUNT) begin
                count_next = '0;
            end
        end

        res.minute_value = minute_now_next;
        res.hour_value   = hour_now_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg        <= 1'b0;
            count_reg         <= '0;
            capture_reg       <= '0;
            minute_now_reg    <= '0;
            hour_now_reg      <= '0;
            minute_before_reg <= '0;
            hour_before_reg   <= '0;
        end else if (item_push) begin
            synced_reg        <= synced_next;
            count_reg         <= count_next;
            capture_reg       <= capture_next;
            minute_now_reg    <= minute_now_next;
            hour_now_reg      <= hour_now_next;
            minute_before_reg <= minute_before_next;
            hour_before_reg   <= hour_before_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dcf_outbuf.sv =====
// dcf_outbuf: two-entry result buffer (output register plus skid entry).
// Depends on dcf_pkg.
`default_nettype none

module dcf_outbuf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire dcf_pkg::dcf_res_t din,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dcf_pkg::dcf_res_t      dout
);

    logic              out_valid_reg, skid_valid_reg;
    dcf_pkg::dcf_res_t out_reg, skid_reg;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign dout      = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (pop || !out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload path, no reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (pop || !out_valid_reg) begin
                out_reg <= din;
            end else begin
                skid_reg <= din;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dcf77_pulse_time_decoder.sv =====
// dcf77_pulse_time_decoder: top level of the DCF77 edge/pulse time decoder.
// Depends on dcf_pkg, dcf_core and dcf_outbuf.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tuser new_level, s_tdata phase_ticks
//  m_       out        m_tvalid/m_tready  m_tdata class, accepted, error, hour, minute
//  cfg_     in         cfg_wr_en          cfg_addr register index, cfg_wdata value
//
// One item per clock while s_tready is high: the state update is a single
// combinational pass from the accepted item and the current state into the result register.
// The result is registered in the output register, or in the skid entry when the output stalls.
// Reset (aresetn low, synchronous) clears state, flags and loads default windows.
// A stalled output holds in the output register; one further item goes to the
// skid entry, after which s_tready drops until the output drains.
`default_nettype none

module dcf77_pulse_time_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dcf_pkg::TICK_W-1:0]        s_tdata,   // [15:0] phase_ticks
    input  wire logic                              s_tuser,   // [0] new_level
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] pulse_class, [2] time_accepted, [3] frame_error,
    // [9:4] hour_value, [16:10] minute_value, [23:17] zero
    output logic [dcf_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dcf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [dcf_pkg::TICK_W-1:0]        cfg_wdata
);

    dcf_pkg::dcf_cfg_t cfg_reg;
    dcf_pkg::dcf_res_t core_res, out_res;
    logic              item_push;

    assign item_push = s_tvalid && s_tready;

    // configuration registers; unused indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_threshold    <= dcf_pkg::GAP_RESET;
            cfg_reg.zero_window_low  <= dcf_pkg::ZERO_LOW_RESET;
            cfg_reg.zero_window_high <= dcf_pkg::ZERO_HIGH_RESET;
            cfg_reg.one_window_low   <= dcf_pkg::ONE_LOW_RESET;
            cfg_reg.one_window_high  <= dcf_pkg::ONE_HIGH_RESET;
        end else if (cfg_wr_en) begin
            case (dcf_pkg::cfg_addr_t'(cfg_addr))
                dcf_pkg::CFG_GAP:       cfg_reg.gap_threshold    <= cfg_wdata;
                dcf_pkg::CFG_ZERO_LOW:  cfg_reg.zero_window_low  <= cfg_wdata;
                dcf_pkg::CFG_ZERO_HIGH: cfg_reg.zero_window_high <= cfg_wdata;
                dcf_pkg::CFG_ONE_LOW:   cfg_reg.one_window_low   <= cfg_wdata;
                dcf_pkg::CFG_ONE_HIGH:  cfg_reg.one_window_high  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dcf_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_push   (item_push),
        .new_level   (s_tuser),
        .phase_ticks (s_tdata),
        .cfg         (cfg_reg),
        .res         (core_res)
    );

    dcf_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_push),
        .din       (core_res),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (out_res)
    );

    assign m_tdata = {7'd0, out_res};

    // every accepted item leaves a result pending on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_push |=> m_tvalid)
        else $error("accepted item produced no pending result");

    // input stalls only when both buffer entries are full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // accepted and frame error are exclusive, and only on a gap result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_res.time_accepted && out_res.frame_error))
        else $error("time accepted and frame error both set");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_res.time_accepted || out_res.frame_error))
            |-> out_res.pulse_class == dcf_pkg::CLS_GAP)
        else $error("frame verdict on a non-gap result");

endmodule

`default_nettype wire
